// File: src/ibfr_pkg.sv
// ibfr_pkg: shared types and constants for the ibus frame receiver
// used by ibfr_ctrl, ibfr_datapath and ibus_frame_receiver; no dependencies
package ibfr_pkg;

  localparam int unsigned CntW     = 5;
  localparam int unsigned ChW      = 4;
  localparam int unsigned Overhead = 3;

  localparam logic [15:0]     SumStart = 16'hFFFF;
  localparam logic [CntW-1:0] MinData  = 5'd18;
  localparam logic [7:0]      CmdByte  = 8'h40;
  localparam logic [7:0]      GapReset = 8'd3;
  localparam logic [7:0]      IdleMax  = 8'hFF;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] channel_index;
    logic [15:0]    channel_value;
    logic           last_channel;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic tick;
    logic byte_seen;
    logic load_len;
    logic store_data;
    logic load_sum_low;
    logic ch_clear;
    logic rd_lo;
    logic rd_hi;
    logic ch_next;
  } ibfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic gap_hit;
    logic len_ok;
    logic data_done;
    logic frame_ok;
    logic last_ch;
  } ibfr_stat_t;

endpackage

// File: src/ibfr_ctrl.sv
// ibfr_ctrl: parse and emit state machine of the ibus frame receiver
// depends on ibfr_pkg; drives ibfr_datapath through ibfr_cmd_t
module ibfr_ctrl import ibfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  ibfr_stat_t stat_i,
  output ibfr_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_LENGTH   = 8'b0000_0001,
    ST_DATA     = 8'b0000_0010,
    ST_SUM_LOW  = 8'b0000_0100,
    ST_SUM_HIGH = 8'b0000_1000,
    ST_DISCARD  = 8'b0001_0000,
    ST_READ_LO  = 8'b0010_0000,
    ST_READ_HI  = 8'b0100_0000,
    ST_SEND     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer;
  logic   byte_xfer;

  assign in_stall_o  = (state_q == ST_READ_LO) || (state_q == ST_READ_HI) ||
                       (state_q == ST_SEND);
  assign out_valid_o = (state_q == ST_SEND);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign byte_xfer   = in_xfer && (kind_e'(in_kind_i) == KIND_BYTE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.tick      = in_xfer && (kind_e'(in_kind_i) == KIND_TICK);
    cmd_o.byte_seen = byte_xfer;

    unique case (state_q)
      ST_LENGTH, ST_DATA, ST_SUM_LOW, ST_SUM_HIGH, ST_DISCARD: begin
        if (byte_xfer) begin
          // an idle gap restarts at the length byte from any phase
          priority if (stat_i.gap_hit || state_q == ST_LENGTH) begin
            if (stat_i.len_ok) begin
              cmd_o.load_len = 1'b1;
              state_d        = ST_DATA;
            end else begin
              state_d = ST_DISCARD;
            end
          end else if (state_q == ST_DATA) begin
            cmd_o.store_data = 1'b1;
            if (stat_i.data_done) state_d = ST_SUM_LOW;
          end else if (state_q == ST_SUM_LOW) begin
            cmd_o.load_sum_low = 1'b1;
            state_d            = ST_SUM_HIGH;
          end else if (state_q == ST_SUM_HIGH) begin
            if (stat_i.frame_ok) begin
              cmd_o.ch_clear = 1'b1;
              state_d        = ST_READ_LO;
            end else begin
              state_d = ST_LENGTH;
            end
          end else begin
            state_d = ST_DISCARD;
          end
        end
      end
      ST_READ_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = ST_READ_HI;
      end
      ST_READ_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        if (!out_stall_i) begin
          if (stat_i.last_ch) begin
            state_d = ST_LENGTH;
          end else begin
            cmd_o.ch_next = 1'b1;
            state_d       = ST_READ_LO;
          end
        end
      end
      default: state_d = ST_LENGTH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LENGTH;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/ibfr_datapath.sv
// ibfr_datapath: counters, checksum, frame store and result register
// depends on ibfr_pkg; commanded by ibfr_ctrl
module ibfr_datapath import ibfr_pkg::*; #(
  parameter int unsigned CHANNELS  = 14,
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic [7:0] rx_byte_i,
  input  ibfr_cmd_t  cmd_i,
  output ibfr_stat_t stat_o,
  output out_item_t  out_item_o
);

  localparam int unsigned Depth = MAX_FRAME - Overhead;
  localparam int unsigned IdxW  = $clog2(Depth);

  localparam logic [CntW-1:0] DepthC   = CntW'(Depth);
  localparam logic [7:0]      MaxLen   = 8'(MAX_FRAME);
  localparam logic [7:0]      OvhLen   = 8'(Overhead);
  localparam logic [ChW-1:0]  LastChan = ChW'(CHANNELS - 1);

  logic [7:0]      gap_q;
  logic [7:0]      idle_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] length_q;
  logic [15:0]     sum_q;
  logic [7:0]      sum_low_q;
  logic [7:0]      store_q [Depth];
  logic [ChW-1:0]  ch_q;
  logic [15:0]     value_q;

  logic [CntW-1:0] count_inc;
  logic [CntW-1:0] addr_lo;
  logic [CntW-1:0] addr_hi;
  logic [CntW-1:0] rd_addr;
  logic [7:0]      rd_byte;

  assign count_inc = count_q + 1'b1;
  assign addr_lo   = {ch_q, 1'b1};
  assign addr_hi   = {ch_q, 1'b0} + CntW'(2);
  assign rd_addr   = cmd_i.rd_hi ? addr_hi : addr_lo;
  // bytes past the store read as zero
  assign rd_byte   = (rd_addr < DepthC) ? store_q[rd_addr[IdxW-1:0]] : 8'h00;

  assign stat_o.gap_hit   = (idle_q >= gap_q);
  assign stat_o.len_ok    = (rx_byte_i <= MaxLen) && (rx_byte_i > OvhLen);
  assign stat_o.data_done = (count_inc == length_q);
  assign stat_o.frame_ok  = (sum_q == {rx_byte_i, sum_low_q}) &&
                            (count_q >= MinData) && (store_q[0] == CmdByte);
  assign stat_o.last_ch   = (ch_q == LastChan);

  assign out_item_o.channel_index = ch_q;
  assign out_item_o.channel_value = value_q;
  assign out_item_o.last_channel  = (ch_q == LastChan);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q     <= GapReset;
      idle_q    <= '0;
      count_q   <= '0;
      length_q  <= '0;
      sum_q     <= '0;
      sum_low_q <= '0;
      ch_q      <= '0;
      for (int i = 0; i < Depth; i++) store_q[i] <= '0;
    end else begin
      if (cfg_we_i) gap_q <= cfg_data_i;
      if (cmd_i.tick && idle_q != IdleMax) idle_q <= idle_q + 1'b1;
      if (cmd_i.byte_seen) idle_q <= '0;
      if (cmd_i.load_len) begin
        count_q  <= '0;
        length_q <= CntW'(rx_byte_i - OvhLen);
        sum_q    <= SumStart - {8'h00, rx_byte_i};
      end
      if (cmd_i.store_data) begin
        if (count_q < DepthC) store_q[count_q[IdxW-1:0]] <= rx_byte_i;
        sum_q   <= sum_q - {8'h00, rx_byte_i};
        count_q <= count_inc;
      end
      if (cmd_i.load_sum_low) sum_low_q <= rx_byte_i;
      if (cmd_i.ch_clear) ch_q <= '0;
      if (cmd_i.ch_next)  ch_q <= ch_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_lo) value_q[7:0]  <= rd_byte;
    if (cmd_i.rd_hi) value_q[15:8] <= rd_byte;
  end

endmodule

// File: src/ibus_frame_receiver.sv
// ibus_frame_receiver: top level of the ibus serial frame receiver
// depends on ibfr_pkg, ibfr_ctrl and ibfr_datapath
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o | in_item_i (kind, rx_byte)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (index, value, last)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (gap_ticks)
//
// a byte or a tick is taken while in_stall_o is low, and the next can follow at once
// a good frame end stalls the input per channel for two frame store reads through
// its single read port, then the output register, plus any out stall
// reset clears all state but value_q, frame store included; gap_ticks resets to 3
// cfg is always ready
module ibus_frame_receiver import ibfr_pkg::*; #(
  parameter int unsigned CHANNELS  = 14,
  parameter int unsigned MAX_FRAME = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  ibfr_cmd_t  cmd;
  ibfr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ibfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_item_i.kind),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ibfr_datapath #(
    .CHANNELS  (CHANNELS),
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rx_byte_i  (in_item_i.rx_byte),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule
